FILE: design/bspb_pkg.sv
// Shared types and constants for the bounded score priority buffer.
// Holds field widths, request codes, the sequencer state type and the entry and result records.
// No dependencies.
package bspb_pkg;

  localparam int CNT_W    = 5;
  localparam int SCORE_W  = 16;
  localparam int HANDLE_W = 16;
  localparam int RANK_W   = 4;
  localparam int REQ_W    = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVICT,
    S_INS_CMP,
    S_INS_WR,
    S_READ,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [SCORE_W-1:0]  score;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic               ev_valid;
    entry_t             ev;
    logic               en_valid;
    entry_t             en;
    logic [CNT_W-1:0]   occupancy;
  } result_t;

endpackage

FILE: design/bspb_mem.sv
// Entry store of the bounded score priority buffer: one write port, one registered read port.
// Depends on bspb_pkg for the entry record.
module bspb_mem #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  bspb_pkg::entry_t          wdata,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output bspb_pkg::entry_t          rdata
);
  import bspb_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/bspb_ctrl.sv
// Sequencer of the bounded score priority buffer: eviction, insertion by shifting, rank read.
// One compare unit is reused for every step of an insertion. Depends on bspb_pkg.
module bspb_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bspb_pkg::CNT_W-1:0]    eff_cap,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bspb_pkg::REQ_W-1:0]    req_type,
  input  logic [bspb_pkg::SCORE_W-1:0]  new_score,
  input  logic [bspb_pkg::HANDLE_W-1:0] new_handle,
  input  logic [bspb_pkg::RANK_W-1:0]   read_rank,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bspb_pkg::result_t             res,
  output logic                          mem_we,
  output logic [$clog2(DEPTH)-1:0]      mem_waddr,
  output bspb_pkg::entry_t              mem_wdata,
  output logic [$clog2(DEPTH)-1:0]      mem_raddr,
  input  bspb_pkg::entry_t              mem_rdata
);
  import bspb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int IW = (AW > CNT_W) ? AW : CNT_W;
  localparam int RW = (AW > RANK_W) ? AW : RANK_W;

  state_t           state, state_next;
  logic [CNT_W-1:0] count;
  logic [AW-1:0]    pos;
  entry_t           new_entry;
  logic             ev_valid, en_valid;
  entry_t           ev_entry, en_entry;

  logic [IW-1:0]    cnt_ext, cnt_m1, cnt_m2;
  logic [RW-1:0]    rank_ext;
  logic             full, rank_hit, less, accept;

  assign cnt_ext  = IW'(count);
  assign cnt_m1   = cnt_ext - IW'(1);
  assign cnt_m2   = cnt_ext - IW'(2);
  assign rank_ext = RW'(read_rank);
  assign full     = (count >= eff_cap) && (count != '0);
  assign rank_hit = {1'b0, read_rank} < count;
  assign less     = mem_rdata.score < new_entry.score;
  assign accept   = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          priority case (req_type)
            REQ_ADD:  state_next = full ? S_EVICT :
                                   ((count == '0) ? S_INS_WR : S_INS_CMP);
            REQ_READ: state_next = rank_hit ? S_READ : S_RESP;
            default:  state_next = S_RESP;
          endcase
        end
      end
      S_EVICT:   state_next = (count == CNT_W'(1)) ? S_INS_WR : S_INS_CMP;
      S_INS_CMP: state_next = less ? ((pos == AW'(1)) ? S_INS_WR : S_INS_CMP) : S_RESP;
      S_INS_WR:  state_next = S_RESP;
      S_READ:    state_next = S_RESP;
      S_RESP:    state_next = res_ready ? S_IDLE : S_RESP;
      default:   state_next = S_IDLE;
    endcase
  end

  // Outputs: handshake and memory port.
  always_comb begin
    in_ready  = (state == S_IDLE);
    res_valid = (state == S_RESP);
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = new_entry;
    mem_raddr = cnt_m1[AW-1:0];
    unique case (state)
      S_IDLE:    mem_raddr = (req_type == REQ_READ) ? rank_ext[AW-1:0] : cnt_m1[AW-1:0];
      S_EVICT:   mem_raddr = cnt_m2[AW-1:0];
      S_INS_CMP: begin
        mem_raddr = pos - AW'(2);
        mem_we    = 1'b1;
        mem_wdata = less ? mem_rdata : new_entry;
      end
      S_INS_WR:  mem_we = 1'b1;
      default:   mem_raddr = cnt_m1[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (accept && (req_type == REQ_CLEAR)) begin
            count <= '0;
          end
        end
        S_EVICT:   count <= count - CNT_W'(1);
        S_INS_CMP: begin
          if (!less) begin
            count <= count + CNT_W'(1);
          end
        end
        S_INS_WR:  count <= count + CNT_W'(1);
        default:   count <= count;
      endcase
    end
  end

  // Payload registers need no reset; they are loaded when a request is accepted.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          new_entry <= '{score: new_score, handle: new_handle};
          pos       <= cnt_ext[AW-1:0];
          ev_valid  <= 1'b0;
          en_valid  <= 1'b0;
          ev_entry  <= '0;
          en_entry  <= '0;
        end
      end
      S_EVICT: begin
        ev_valid <= 1'b1;
        ev_entry <= mem_rdata;
        pos      <= cnt_m1[AW-1:0];
      end
      S_INS_CMP: begin
        if (less) begin
          pos <= pos - AW'(1);
        end
      end
      S_READ: begin
        en_valid <= 1'b1;
        en_entry <= mem_rdata;
      end
      default: pos <= pos;
    endcase
  end

  assign res = '{ev_valid: ev_valid, ev: ev_entry, en_valid: en_valid, en: en_entry,
                 occupancy: count};

endmodule

FILE: design/bounded_score_priority_buffer.sv
// Top level of the bounded score priority buffer: capacity register, output register, store.
// Instantiates bspb_mem and bspb_ctrl; depends on bspb_pkg.
//
//   Channel    Handshake              Payload
//   request    in_valid / in_ready    req_type, new_score, new_handle, read_rank
//   result     out_valid / out_ready  evicted_*, entry_*, occupancy
//   config     cfg_we                 cfg_wdata (capacity_in_use)
//
// An add walks the entries that rank below the new score and moves each down one place
// (up to DEPTH - 1 of them), after first evicting the lowest entry when the buffer is
// full. A read of a held rank fetches that entry; a clear or an unknown request goes
// straight to the response step. The pace is set by the entry store's single read port,
// which the sequencer walks one rank per cycle while the compare unit decides each move.
// Reset is synchronous and needs no clearing pass: only entries below the count are read.
// A result waiting in the output register holds the sequencer in its response step.
module bounded_score_priority_buffer #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bspb_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bspb_pkg::REQ_W-1:0]    req_type,
  input  logic [bspb_pkg::SCORE_W-1:0]  new_score,
  input  logic [bspb_pkg::HANDLE_W-1:0] new_handle,
  input  logic [bspb_pkg::RANK_W-1:0]   read_rank,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          evicted_valid,
  output logic [bspb_pkg::SCORE_W-1:0]  evicted_score,
  output logic [bspb_pkg::HANDLE_W-1:0] evicted_handle,
  output logic                          entry_valid,
  output logic [bspb_pkg::SCORE_W-1:0]  entry_score,
  output logic [bspb_pkg::HANDLE_W-1:0] entry_handle,
  output logic [bspb_pkg::CNT_W-1:0]    occupancy
);
  import bspb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  // The 5-bit capacity register can never ask for more than 31 entries.
  localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'(CAP_MAX);

  logic [CNT_W-1:0] capacity_in_use;
  logic [CNT_W-1:0] eff_cap;

  logic             res_valid, res_ready;
  result_t          res, out_res;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  entry_t           mem_wdata, mem_rdata;

  // Capacity register. Zero acts as one, and anything above the store depth acts as the depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_in_use <= cfg_wdata;
    end
  end

  always_comb begin
    if (capacity_in_use == '0) begin
      eff_cap = CNT_W'(1);
    end else if (capacity_in_use > CAP_LIM) begin
      eff_cap = CAP_LIM;
    end else begin
      eff_cap = capacity_in_use;
    end
  end

  bspb_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bspb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .eff_cap    (eff_cap),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .new_score  (new_score),
    .new_handle (new_handle),
    .read_rank  (read_rank),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // Output register. A new result loads when the register is empty or is being drained
  // by a transfer in the same cycle.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign evicted_valid  = out_res.ev_valid;
  assign evicted_score  = out_res.ev.score;
  assign evicted_handle = out_res.ev.handle;
  assign entry_valid    = out_res.en_valid;
  assign entry_score    = out_res.en.score;
  assign entry_handle   = out_res.en.handle;
  assign occupancy      = out_res.occupancy;

  // A result never reports both an eviction and a read hit.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(evicted_valid && entry_valid))
    else $error("result reports both an eviction and a read");

  // The sequencer takes no second request in the cycle after a transfer.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while the previous one is still in progress");

  // The reported occupancy never exceeds the store depth.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(occupancy) <= DEPTH))
    else $error("occupancy beyond store depth");

  // A new result is only loaded when the output register can take it.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(occupancy) && $stable(evicted_valid)))
    else $error("stalled result overwritten");

endmodule
